// ===== src/rpy_pkg.sv =====
// Package for the Euler ZYX rotation-matrix pipeline.
// Holds the CORDIC arctangent table and shared fixed-point constants.
package rpy_pkg;

  localparam int unsigned WorkBits    = 30;
  localparam int unsigned CordicSteps = 30;
  localparam int unsigned StepsPerStg = 3;
  localparam int unsigned CordicStgs  = CordicSteps / StepsPerStg;
  localparam int unsigned XyBits      = 33;
  localparam int unsigned ZBits       = 33;
  localparam logic signed [XyBits-1:0] GainInv = 33'sd652032874;

  typedef logic signed [XyBits-1:0] xy_t;
  typedef logic signed [ZBits-1:0]  z_t;

  // CORDIC state for one angle.
  typedef struct packed {
    xy_t        x;
    xy_t        y;
    z_t         z;
    logic [1:0] quad;
  } cordic_t;

  // atan(2^-i) in units of 2^-32 turn.
  function automatic z_t atan_turn(input logic [4:0] idx);
    z_t r;
    case (idx)
      5'd0:  r = 33'sd536870912;
      5'd1:  r = 33'sd316933406;
      5'd2:  r = 33'sd167458907;
      5'd3:  r = 33'sd85004756;
      5'd4:  r = 33'sd42667331;
      5'd5:  r = 33'sd21354465;
      5'd6:  r = 33'sd10679838;
      5'd7:  r = 33'sd5340245;
      5'd8:  r = 33'sd2670163;
      5'd9:  r = 33'sd1335087;
      5'd10: r = 33'sd667544;
      5'd11: r = 33'sd333772;
      5'd12: r = 33'sd166886;
      5'd13: r = 33'sd83443;
      5'd14: r = 33'sd41722;
      5'd15: r = 33'sd20861;
      5'd16: r = 33'sd10430;
      5'd17: r = 33'sd5215;
      5'd18: r = 33'sd2608;
      5'd19: r = 33'sd1304;
      5'd20: r = 33'sd652;
      5'd21: r = 33'sd326;
      5'd22: r = 33'sd163;
      5'd23: r = 33'sd81;
      5'd24: r = 33'sd41;
      5'd25: r = 33'sd20;
      5'd26: r = 33'sd10;
      5'd27: r = 33'sd5;
      5'd28: r = 33'sd3;
      5'd29: r = 33'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Rounded Q.30 product.
  function automatic xy_t mul_q30(input xy_t a, input xy_t b);
    logic signed [2*XyBits-1:0] p;
    p = a * b + (66'sd1 <<< (WorkBits - 1));
    return xy_t'(p >>> WorkBits);
  endfunction

endpackage

// ===== src/rpy_cordic_stage.sv =====
// One registered CORDIC stage of three micro-rotations.
// Depends on rpy_pkg.
module rpy_cordic_stage #(
  parameter int unsigned FirstStep = 0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  rpy_pkg::cordic_t in_i,
  output rpy_pkg::cordic_t out_o
);
  import rpy_pkg::*;

  cordic_t v_d, out_q;

  // Three dependent rotations.
  always_comb begin
    xy_t dx, dy;
    v_d = in_i;
    for (int unsigned k = 0; k < StepsPerStg; k++) begin
      dx = v_d.y >>> (FirstStep + k);
      dy = v_d.x >>> (FirstStep + k);
      if (!v_d.z[ZBits-1]) begin
        v_d.x = v_d.x - dx;
        v_d.y = v_d.y + dy;
        v_d.z = v_d.z - atan_turn(5'(FirstStep + k));
      end else begin
        v_d.x = v_d.x + dx;
        v_d.y = v_d.y - dy;
        v_d.z = v_d.z + atan_turn(5'(FirstStep + k));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) out_q <= v_d;
  end

  assign out_o = out_q;
endmodule

// ===== src/rpy_sincos.sv =====
// Pipelined sine and cosine of one turn-fraction angle.
// Depends on rpy_pkg and rpy_cordic_stage; the CORDIC stages feed a registered quadrant restore.
module rpy_sincos #(
  parameter int unsigned AngleBits = 16
) (
  input  logic                clk_i,
  input  logic [AngleBits-1:0] turn_i,
  input  logic                en_i,
  output rpy_pkg::xy_t        sin_o,
  output rpy_pkg::xy_t        cos_o
);
  import rpy_pkg::*;

  cordic_t chain [CordicStgs+1];
  logic [31:0] a;
  logic [1:0]  q;
  logic [31:0] ru;
  xy_t sin_q, cos_q;

  // Quadrant reduction.
  always_comb begin
    a  = {turn_i, {(32-AngleBits){1'b0}}};
    q  = 2'((a + 32'h2000_0000) >> 30);
    ru = a - {q, 30'd0};
    chain[0].x    = GainInv;
    chain[0].y    = '0;
    chain[0].z    = z_t'($signed(ru));
    chain[0].quad = q;
  end

  for (genvar g = 0; g < CordicStgs; g++) begin : g_stage
    rpy_cordic_stage #(.FirstStep(g * StepsPerStg)) u_stage (
      .clk_i (clk_i),
      .en_i  (en_i),
      .in_i  (chain[g]),
      .out_o (chain[g+1])
    );
  end

  // Quadrant restore.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (chain[CordicStgs].quad)
        2'd0: begin
          cos_q <= chain[CordicStgs].x;  sin_q <= chain[CordicStgs].y;
        end
        2'd1: begin
          cos_q <= -chain[CordicStgs].y; sin_q <= chain[CordicStgs].x;
        end
        2'd2: begin
          cos_q <= -chain[CordicStgs].x; sin_q <= -chain[CordicStgs].y;
        end
        default: begin
          cos_q <= chain[CordicStgs].y;  sin_q <= -chain[CordicStgs].x;
        end
      endcase
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;
endmodule

// ===== src/rpy_to_rotation_matrix.sv =====
// Top level: Euler ZYX pose to rotation matrix, pipelined.
// Depends on rpy_pkg and rpy_sincos.
//
//  channel | dir | tdata (low bit up)                       | tuser
//  s_axis  | in  | pos_x, pos_y, pos_z, roll, pitch, yaw    | -
//  m_axis  | out | rot_00..rot_22, trans_x, trans_y, trans_z | -
//
// One pose per cycle while the output is not stalled; the pipe is the ten
// three-step CORDIC stages, quadrant restore and three product stages.
// The whole pipe advances when the output slot is empty or being taken,
// so a stall freezes every stage and nothing is lost or repeated.
// Reset clears only the valid bits.
module rpy_to_rotation_matrix #(
  parameter int unsigned ANGLE_BITS     = 16,
  parameter int unsigned COEF_FRAC_BITS = 14
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [143:0] s_axis_tdata,  // pos_x, pos_y, pos_z, roll, pitch, yaw
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [239:0] m_axis_tdata   // rot_00..rot_22, trans_x, trans_y, trans_z
);
  import rpy_pkg::*;

  localparam int unsigned Lat = CordicStgs + 4;
  localparam int unsigned Sh  = WorkBits - COEF_FRAC_BITS;

  logic en;
  logic [Lat-1:0] vld_q;
  logic [95:0] pos_q [Lat];
  xy_t sr, cr, sp, cp, sy, cy;
  // Product stage one.
  xy_t t1_q, t2_q, r00_q, r10_q, r21_q, r22_q, sycr_q, sysr_q, cycr_q, cysr_q;
  xy_t sr1_q, cr1_q, sp1_q;
  // Product stage two.
  xy_t a01_q, a02_q, a11_q, a12_q, r00b_q, r10b_q, r21b_q, r22b_q, sp2_q;
  logic [15:0] coef_q [9];

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Lat-1];

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
    end
  end

  // Translation delay line.
  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_q[0] <= s_axis_tdata[95:0];
      for (int unsigned i = 1; i < Lat; i++) pos_q[i] <= pos_q[i-1];
    end
  end

  rpy_sincos #(.AngleBits(ANGLE_BITS)) u_roll (
    .clk_i(clk_i), .turn_i(ANGLE_BITS'(s_axis_tdata[96 +: 16])), .en_i(en),
    .sin_o(sr), .cos_o(cr));
  rpy_sincos #(.AngleBits(ANGLE_BITS)) u_pitch (
    .clk_i(clk_i), .turn_i(ANGLE_BITS'(s_axis_tdata[112 +: 16])), .en_i(en),
    .sin_o(sp), .cos_o(cp));
  rpy_sincos #(.AngleBits(ANGLE_BITS)) u_yaw (
    .clk_i(clk_i), .turn_i(ANGLE_BITS'(s_axis_tdata[128 +: 16])), .en_i(en),
    .sin_o(sy), .cos_o(cy));

  function automatic logic [15:0] to_coef(input xy_t v);
    logic signed [XyBits:0] r;
    logic signed [XyBits:0] one;
    one = (XyBits+1)'(1) <<< COEF_FRAC_BITS;
    if (Sh > 0) r = ($signed({v[XyBits-1], v}) + ((XyBits+1)'(1) <<< (Sh - 1))) >>> Sh;
    else        r = $signed({v[XyBits-1], v});
    if (r > one)  r = one;
    if (r < -one) r = -one;
    return r[15:0];
  endfunction

  // Products and output rounding.
  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_q <= mul_q30(cy, sp);     t2_q <= mul_q30(sy, sp);
      r00_q <= mul_q30(cy, cp);    r10_q <= mul_q30(sy, cp);
      r21_q <= mul_q30(cp, sr);    r22_q <= mul_q30(cp, cr);
      sycr_q <= mul_q30(sy, cr);   sysr_q <= mul_q30(sy, sr);
      cycr_q <= mul_q30(cy, cr);   cysr_q <= mul_q30(cy, sr);
      sr1_q <= sr; cr1_q <= cr; sp1_q <= sp;

      a01_q <= mul_q30(t1_q, sr1_q) - sycr_q;
      a02_q <= mul_q30(t1_q, cr1_q) + sysr_q;
      a11_q <= mul_q30(t2_q, sr1_q) + cycr_q;
      a12_q <= mul_q30(t2_q, cr1_q) - cysr_q;
      r00b_q <= r00_q; r10b_q <= r10_q; r21b_q <= r21_q; r22b_q <= r22_q;
      sp2_q <= -sp1_q;

      coef_q[0] <= to_coef(r00b_q); coef_q[1] <= to_coef(a01_q);
      coef_q[2] <= to_coef(a02_q);  coef_q[3] <= to_coef(r10b_q);
      coef_q[4] <= to_coef(a11_q);  coef_q[5] <= to_coef(a12_q);
      coef_q[6] <= to_coef(sp2_q);  coef_q[7] <= to_coef(r21b_q);
      coef_q[8] <= to_coef(r22b_q);
    end
  end

  assign m_axis_tdata = {pos_q[Lat-1], coef_q[8], coef_q[7], coef_q[6], coef_q[5],
                         coef_q[4], coef_q[3], coef_q[2], coef_q[1], coef_q[0]};
endmodule

// ===== sim/rpy_to_rotation_matrix_tb.sv =====
// Testbench for rpy_to_rotation_matrix: streams poses through the pipeline and
// checks each rotation matrix and translation against a CORDIC-based predictor.
// Depends on the rpy_to_rotation_matrix RTL and its package.
module rpy_to_rotation_matrix_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned AngleBits    = 16;
  localparam int unsigned CoefFracBits = 14;
  localparam int unsigned NumRandom    = 1200;
  localparam int unsigned CycleLimit   = 400000;

  typedef struct packed {
    logic [15:0] yaw;
    logic [15:0] pitch;
    logic [15:0] roll;
    logic [31:0] pos_z;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
  } pose_t;

  typedef struct packed {
    logic [31:0] trans_z;
    logic [31:0] trans_y;
    logic [31:0] trans_x;
    logic [15:0] r22, r21, r20, r12, r11, r10, r02, r01, r00;
  } frame_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [239:0] m_axis_tdata;

  rpy_to_rotation_matrix dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  pose_t   pose_queue[$];
  frame_t  frame_queue[$];
  int      mismatch_count;
  longint  cycle_count;
  bit      idle_enable;
  int      hold_off_cycles;

  // Arctangent table in units of 2^-32 turn.
  longint atan_lut[30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1};

  function automatic longint rnd_prod(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // Quarter-turn reduction then 30 CORDIC rotations, results in Q.30.
  function automatic void angle_sincos(logic [15:0] ang, output longint sn,
                                       output longint cs);
    logic [31:0] a, ru;
    logic [1:0]  quad;
    longint      x, y, z, dx, dy;
    a    = 32'(ang[AngleBits-1:0]) << (32 - AngleBits);
    quad = 2'((a + 32'h2000_0000) >> 30);
    ru   = a - (32'(quad) << 30);
    z    = longint'($signed(ru));
    x    = 652032874;
    y    = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_lut[i];
      end else begin
        x += dx; y -= dy; z += atan_lut[i];
      end
    end
    case (quad)
      2'd0: begin cs = x;  sn = y;  end
      2'd1: begin cs = -y; sn = x;  end
      2'd2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
  endfunction

  // Round Q.30 down to the coefficient format and clamp to +-1.0.
  function automatic logic [15:0] to_q14(longint v);
    longint r, one;
    one = 64'sd1 <<< CoefFracBits;
    r = (v + (64'sd1 <<< (29 - CoefFracBits))) >>> (30 - CoefFracBits);
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[15:0];
  endfunction

  function automatic frame_t predict_frame(pose_t p);
    frame_t f;
    longint sr, cr, sp, cp, sy, cy, t1, t2;
    angle_sincos(p.roll, sr, cr);
    angle_sincos(p.pitch, sp, cp);
    angle_sincos(p.yaw, sy, cy);
    t1 = rnd_prod(cy, sp);
    t2 = rnd_prod(sy, sp);
    f.r00 = to_q14(rnd_prod(cy, cp));
    f.r01 = to_q14(rnd_prod(t1, sr) - rnd_prod(sy, cr));
    f.r02 = to_q14(rnd_prod(t1, cr) + rnd_prod(sy, sr));
    f.r10 = to_q14(rnd_prod(sy, cp));
    f.r11 = to_q14(rnd_prod(t2, sr) + rnd_prod(cy, cr));
    f.r12 = to_q14(rnd_prod(t2, cr) - rnd_prod(cy, sr));
    f.r20 = to_q14(-sp);
    f.r21 = to_q14(rnd_prod(cp, sr));
    f.r22 = to_q14(rnd_prod(cp, cr));
    f.trans_x = p.pos_x;
    f.trans_y = p.pos_y;
    f.trans_z = p.pos_z;
    return f;
  endfunction

  function automatic pose_t random_pose();
    pose_t p;
    p = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
    // Angles land near quadrant and octant boundaries part of the time.
    if ($urandom_range(0, 3) == 0) p.roll  = 16'($urandom_range(0, 7) * 8192 + $urandom_range(0, 4) - 2);
    if ($urandom_range(0, 3) == 0) p.pitch = 16'($urandom_range(0, 7) * 8192 + $urandom_range(0, 4) - 2);
    if ($urandom_range(0, 3) == 0) p.yaw   = 16'($urandom_range(0, 7) * 8192 + $urandom_range(0, 4) - 2);
    return p;
  endfunction

  // Appends one pose to the pending queue.
  task automatic enqueue_pose(input pose_t p);
    pose_queue.insert(pose_queue.size(), p);
  endtask

  // Clock and cycle limit.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Driver: offers the head of the pending queue, idling at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        frame_queue.insert(frame_queue.size(), predict_frame(pose_t'(s_axis_tdata)));
        void'(pose_queue.pop_front());
      end
      if ((!s_axis_tvalid || s_axis_tready)) begin
        if (pose_queue.size() > 0 &&
            !(idle_enable && $urandom_range(0, 99) < 37)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pose_queue[0];
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver hold-off countdown.
  always @(posedge clk_i) begin
    if (hold_off_cycles > 0) hold_off_cycles <= hold_off_cycles - 1;
  end

  // Monitor: checks each accepted frame against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    frame_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = frame_t'(m_axis_tdata);
        if (frame_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected frame %h", got);
        end else begin
          want = frame_queue.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("frame mismatch");
              $display("  expected %h", want);
              $display("  actual   %h", got);
            end
          end
        end
      end
      if (hold_off_cycles > 0) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(idle_enable && $urandom_range(0, 99) < 37);
      end
    end
  end

  task automatic wait_drained();
    while (pose_queue.size() != 0 || s_axis_tvalid || frame_queue.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    pose_t p;
    mismatch_count  = 0;
    cycle_count     = 0;
    idle_enable     = 1;
    hold_off_cycles = 0;
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    m_axis_tready   = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni = 1'b1;

    // Directed: field extremes, quadrant boundaries and angle wrap.
    enqueue_pose('0);
    enqueue_pose('1);
    enqueue_pose({16'h8000, 16'h8000, 16'h8000,
                  32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000});
    enqueue_pose({16'h4000, 16'h4000, 16'h4000,
                  32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
    enqueue_pose({16'hc000, 16'hc000, 16'hc000, 96'h0});
    enqueue_pose({16'h2000, 16'h2000, 16'h2000, 96'h1});
    enqueue_pose({16'h1fff, 16'h6000, 16'he000, 96'h0});
    enqueue_pose({16'hffff, 16'h0001, 16'h7fff, 96'h0});
    enqueue_pose({16'h4000, 16'h0000, 16'h0000, 96'h0});
    enqueue_pose({16'h0000, 16'h4000, 16'h0000, 96'h0});
    enqueue_pose({16'h0000, 16'h0000, 16'h4000, 96'h0});
    enqueue_pose({16'h5555, 16'haaaa, 16'h5555, {3{32'haaaa_5555}}});
    wait_drained();

    // Sender pause until every result is back, then a burst with no idling.
    idle_enable = 0;
    for (int i = 0; i < 200; i++) enqueue_pose(random_pose());
    wait_drained();
    idle_enable = 1;

    // Long receiver hold-off while the sender keeps offering poses.
    hold_off_cycles = 300;
    for (int i = 0; i < 100; i++) enqueue_pose(random_pose());
    wait_drained();

    for (int i = 0; i < NumRandom - 300; i++) begin
      p = random_pose();
      enqueue_pose(p);
    end
    wait_drained();
    repeat (50) @(posedge clk_i);

    if (mismatch_count == 0 && frame_queue.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/rpy_pkg.sv
src/rpy_cordic_stage.sv
src/rpy_sincos.sv
src/rpy_to_rotation_matrix.sv
sim/rpy_to_rotation_matrix_tb.sv
